FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication or expression, checked at every rising edge outside reset.
`define IGFR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("igfr assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define IGFR_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
    else $error("igfr next-cycle assertion failed");

`endif

FILE: rtl/igfr_pkg.sv
`default_nettype none

package igfr_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 64;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned POS_W            = 6;
  localparam int unsigned TICKS_W          = 10;

  localparam logic [TICKS_W-1:0] IDLE_TICKS_RESET = 10'd30;
  localparam logic [TICKS_W-1:0] IDLE_MAX         = 10'd1023;

  // Input word kinds; the fourth code carries no meaning and is ignored.
  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

endpackage

`default_nettype wire

FILE: rtl/igfr_if.sv
`default_nettype none

interface igfr_in_if import igfr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface igfr_out_if import igfr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  frame_length;
  logic              last;

  modport source (output valid, output data_byte, output byte_position,
                  output frame_length, output last, input ready);
  modport sink   (input valid, input data_byte, input byte_position,
                  input frame_length, input last, output ready);
endinterface

interface igfr_cfg_if import igfr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [TICKS_W-1:0] idle_ticks;

  modport source (output valid, output idle_ticks, input ready);
  modport sink   (input valid, input idle_ticks, output ready);
endinterface

`default_nettype wire

FILE: rtl/idle_gap_frame_receiver_unit.sv
// Byte, tick and release words are accepted only in the idle state, never while a dump runs.
// A tick that completes a frame starts a dump of the N stored bytes: a memory read state and
// then an output load state per byte, and a single empty-word state for an empty frame.
// The single read port of the frame memory, its registered data and sink stalls set the dump pace.
// Reset (rst_ni low, asynchronous) clears the counters, the flags and the output valid and
// loads idle_ticks with 30; the frame memory itself is not cleared.
`default_nettype none

module idle_gap_frame_receiver_unit import igfr_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  igfr_cfg_if.sink     cfg_i,
  igfr_in_if.sink      in_i,
  igfr_out_if.source   out_o
);

  localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // The sequencer owns the single memory port: bytes are written only while idle,
  // and the dump reads only after the frame is locked, so a write and a read of
  // the same entry can never meet in one cycle.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_EMPTY
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   count_q;
  logic [TICKS_W-1:0] idle_q;
  logic               recv_q;
  logic               lock_q;
  logic [TICKS_W-1:0] ticks_q;
  logic [IDX_W-1:0]   pos_q;
  logic [IDX_W-1:0]   len_q;

  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_data_q;
  logic [POS_W-1:0]   out_pos_q;
  logic [POS_W-1:0]   out_len_q;
  logic               out_last_q;

  logic [BYTE_W-1:0]  frame_mem [BUFFER_DEPTH];
  logic [BYTE_W-1:0]  rd_data_q;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic               mem_we;
  logic [IDX_W-1:0]   count_inc;
  logic               pos_last;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  // The output register can take a new word when it is empty or being drained.
  assign out_free = !out_valid_q || out_o.ready;

  // A new word enters the output register in the load and empty-frame states.
  assign out_load = out_free && ((state_q == S_LOAD) || (state_q == S_EMPTY));

  // A full store drops the partial frame and restarts at position zero.
  assign count_inc = (count_q == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : count_q + IDX_W'(1);
  assign pos_last  = (pos_q == len_q - IDX_W'(1));

  assign mem_we = in_acc && (in_i.kind == KIND_BYTE) && !lock_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[count_q] <= in_i.byte_value;
    end
    if (state_q == S_READ) begin
      rd_data_q <= frame_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idle_q      <= '0;
      recv_q      <= 1'b0;
      lock_q      <= 1'b0;
      ticks_q     <= IDLE_TICKS_RESET;
      pos_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_pos_q   <= '0;
      out_len_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        ticks_q <= cfg_i.idle_ticks;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_i.kind)
              KIND_BYTE: begin
                if (!lock_q) begin
                  count_q <= count_inc;
                  idle_q  <= '0;
                  recv_q  <= 1'b1;
                end
              end
              KIND_TICK: begin
                if (recv_q && !lock_q) begin
                  // The compare uses the count from before this tick's increment.
                  if (idle_q != IDLE_MAX) begin
                    idle_q <= idle_q + TICKS_W'(1);
                  end
                  if (idle_q >= ticks_q) begin
                    recv_q  <= 1'b0;
                    lock_q  <= 1'b1;
                    pos_q   <= '0;
                    len_q   <= count_q;
                    state_q <= (count_q == '0) ? S_EMPTY : S_READ;
                  end
                end
              end
              KIND_RELEASE: begin
                lock_q <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          // Read data stays in rd_data_q while the sink stalls.
          if (out_free) begin
            out_data_q  <= rd_data_q;
            out_pos_q   <= POS_W'(pos_q);
            out_len_q   <= POS_W'(len_q);
            out_last_q  <= pos_last;
            pos_q       <= pos_q + IDX_W'(1);
            state_q     <= pos_last ? S_IDLE : S_READ;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_data_q  <= '0;
            out_pos_q   <= '0;
            out_len_q   <= '0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.data_byte     = out_data_q;
  assign out_o.byte_position = out_pos_q;
  assign out_o.frame_length  = out_len_q;
  assign out_o.last          = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/igfr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module igfr_checker import igfr_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [BYTE_W-1:0] out_data_i,
  input wire logic [POS_W-1:0]  out_pos_i,
  input wire logic [POS_W-1:0]  out_len_i,
  input wire logic              out_last_i
);

  // A stalled result word keeps its contents.
  `IGFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i) && $stable(out_pos_i) && $stable(out_len_i) && $stable(out_last_i))

  // No input is taken while a dump still has words to send.
  `IGFR_ASSERT(a_busy_dump, clk_i, rst_ni, (out_valid_i && !out_last_i) |-> !in_ready_i)

  // The final word sits at the end of the frame, or is the single empty word.
  `IGFR_ASSERT(a_last_pos, clk_i, rst_ni, (out_valid_i && out_last_i) |-> ((out_len_i == '0 && out_pos_i == '0) || (out_pos_i + POS_W'(1) == out_len_i)))

  // Words of one dump come out in position order.
  `IGFR_ASSERT_NEXT(a_pos_order, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i, !out_valid_i || (out_pos_i == $past(out_pos_i) + POS_W'(1)))

endmodule

bind idle_gap_frame_receiver_unit igfr_checker u_igfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data_byte),
  .out_pos_i   (out_o.byte_position),
  .out_len_i   (out_o.frame_length),
  .out_last_i  (out_o.last)
);

`default_nettype wire
